### sv/ocl_pkg.sv
// shared types, constants and the pattern function for the opponent-color lbp block
// no dependencies; compiled first
`timescale 1ns / 1ps
`default_nettype none

package ocl_pkg;

  localparam int PIX_W  = 24;
  localparam int CH_W   = 8;
  localparam int ROW_W  = 12;
  localparam int CCOL_W = 11;
  localparam int CFG_W  = 12;
  localparam int IDX_W  = 1;
  localparam int NCODES = 6;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [ROW_W-1:0] MIN_SIZE   = 12'd3;
  localparam logic [ROW_W-1:0] MAX_HEIGHT = 12'd4095;

  // neighbor and center channel of each code
  localparam logic [1:0] PAIR_NBR [NCODES] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};
  localparam logic [1:0] PAIR_CTR [NCODES] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd0, 2'd1};

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [NCODES-1:0][CH_W-1:0] code_set_t;

  // 3x3 window around the center pixel
  typedef struct packed {
    pixel_t tl;
    pixel_t t;
    pixel_t tr;
    pixel_t l;
    pixel_t ctr;
    pixel_t rt;
    pixel_t bl;
    pixel_t b;
    pixel_t br;
  } win_t;

  // position info carried with a word from the counter stage
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [ROW_W-1:0]  center_row;
    logic [CCOL_W-1:0] center_col;
    logic              emit;
    logic              last;
  } pos_t;

  function automatic logic [CH_W-1:0] chan_of(input pixel_t px, input logic [1:0] ch);
    return px[CH_W*ch +: CH_W];
  endfunction

  function automatic logic [CH_W-1:0] lbp_code(input win_t w, input logic [1:0] nc,
                                               input logic [1:0] cc);
    logic [CH_W-1:0] cv;
    logic [CH_W-1:0] code;
    cv = chan_of(w.ctr, cc);
    code[3] = (cv >= chan_of(w.tl, nc));
    code[2] = (cv >= chan_of(w.t, nc));
    code[1] = (cv >= chan_of(w.tr, nc));
    code[0] = (cv >= chan_of(w.rt, nc));
    code[7] = (cv >= chan_of(w.br, nc));
    code[6] = (cv >= chan_of(w.b, nc));
    code[5] = (cv >= chan_of(w.bl, nc));
    code[4] = (cv >= chan_of(w.l, nc));
    return code;
  endfunction

endpackage

`default_nettype wire

### sv/ocl_if.sv
// valid/ready channel interfaces for pixel words and result words
// depends on ocl_pkg
`timescale 1ns / 1ps
`default_nettype none

interface ocl_pix_if;
  import ocl_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] chan_zero;
  logic [CH_W-1:0] chan_one;
  logic [CH_W-1:0] chan_two;
  logic            frame_start;

  modport source (output valid, chan_zero, chan_one, chan_two, frame_start, input ready);
  modport sink   (input valid, chan_zero, chan_one, chan_two, frame_start, output ready);
endinterface

interface ocl_res_if;
  import ocl_pkg::*;
  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   code_n0_c0;
  logic [CH_W-1:0]   code_n1_c1;
  logic [CH_W-1:0]   code_n2_c2;
  logic [CH_W-1:0]   code_n1_c0;
  logic [CH_W-1:0]   code_n2_c0;
  logic [CH_W-1:0]   code_n2_c1;
  logic [ROW_W-1:0]  center_row;
  logic [CCOL_W-1:0] center_col;
  logic              frame_last;

  modport source (output valid, code_n0_c0, code_n1_c1, code_n2_c2, code_n1_c0,
                  code_n2_c0, code_n2_c1, center_row, center_col, frame_last,
                  input ready);
  modport sink   (input valid, code_n0_c0, code_n1_c1, code_n2_c2, code_n1_c0,
                  code_n2_c0, code_n2_c1, center_row, center_col, frame_last,
                  output ready);
endinterface

`default_nettype wire

### sv/ocl_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ocl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/ocl_position.sv
// frame size registers and raster position counters
// depends on ocl_pkg
`timescale 1ns / 1ps
`default_nettype none

module ocl_position
  import ocl_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [IDX_W-1:0]             cfg_index,
  input  wire logic [CFG_W-1:0]             cfg_data,
  input  wire logic                         advance,
  input  wire logic                         frame_start,
  output logic      [$clog2(MAX_WIDTH)-1:0] col,
  output pos_t                              pos
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;

  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic [CW-1:0]    col_count;
  logic [ROW_W-1:0] row_count;

  logic [EW-1:0]    fw_ext;
  logic [EW-1:0]    w;
  logic [ROW_W-1:0] h;
  logic [EW-1:0]    c_pre;
  logic [EW-1:0]    c_cur;
  logic [ROW_W-1:0] r_pre;
  logic [ROW_W-1:0] r_wrap;
  logic [ROW_W-1:0] r_cur;
  logic [EW-1:0]    c_inc;
  logic [ROW_W-1:0] r_inc;
  logic [CW-1:0]    col_count_next;
  logic [ROW_W-1:0] row_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CFG_W'(640);
      frame_height <= CFG_W'(480);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective sizes, saturated to the legal range
  always_comb begin
    fw_ext = EW'(frame_width);
    if (fw_ext < EW'(MIN_SIZE)) begin
      w = EW'(MIN_SIZE);
    end else if (fw_ext > EW'(MAX_WIDTH)) begin
      w = EW'(MAX_WIDTH);
    end else begin
      w = fw_ext;
    end
    h = (frame_height < MIN_SIZE) ? MIN_SIZE : frame_height;
  end

  // position of the arriving pixel, with wrap after a frame size change
  always_comb begin
    c_pre = frame_start ? '0 : EW'(col_count);
    r_pre = frame_start ? '0 : row_count;
    if (c_pre >= w) begin
      c_cur  = '0;
      r_wrap = r_pre + 1'b1;
    end else begin
      c_cur  = c_pre;
      r_wrap = r_pre;
    end
    r_cur = (r_wrap >= h) ? '0 : r_wrap;

    c_inc = c_cur + 1'b1;
    r_inc = r_cur + 1'b1;
    if (c_inc >= w) begin
      col_count_next = '0;
      row_count_next = (r_inc >= h) ? '0 : r_inc;
    end else begin
      col_count_next = CW'(c_inc);
      row_count_next = r_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (advance) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  always_comb begin
    col            = CW'(c_cur);
    pos.row        = r_cur;
    pos.center_row = r_cur - 1'b1;
    pos.center_col = CCOL_W'(c_cur - 1'b1);
    pos.emit       = (r_cur >= ROW_W'(2)) && (c_cur >= EW'(2));
    pos.last       = (r_cur == h - 1'b1) && (c_cur == w - 1'b1);
  end

endmodule

`default_nettype wire

### sv/ocl_codes.sv
// six opponent-color patterns from one 3x3 window
// depends on ocl_pkg
`timescale 1ns / 1ps
`default_nettype none

module ocl_codes
  import ocl_pkg::*;
(
  input  wire win_t win,
  output code_set_t codes
);

  always_comb begin
    for (int k = 0; k < NCODES; k++) begin
      codes[k] = lbp_code(win, PAIR_NBR[k], PAIR_CTR[k]);
    end
  end

endmodule

`default_nettype wire

### sv/opponent_color_lbp_3x3.sv
// top level of the opponent-color 3x3 local binary pattern block
// depends on ocl_pkg, ocl_if, ocl_ram, ocl_position and ocl_codes
//
// usage
//   pix: raster-order pixel words, three 8-bit channels and a frame_start
//     flag that puts the position counters back to row 0, column 0
//   res: one result word per interior pixel, six 8-bit codes plus the
//     center position and a frame_last flag; border pixels give no word
//   cfg: write-only port, frame_width (index 0) and frame_height (index 1),
//     written only while the block is idle
// timing
//   one pixel word accepted per clock unless stalled; the edge accepting the
//   pixel completing a window (its bottom-right neighbor) loads the input register
//   and line-store read; the word leaving that stage loads the output register
//   line stores are read at the arriving column and written back as the word
//   leaves the input register; a same-column write/read pair is bypassed
// reset
//   rst clears the counters, the window and all valid flags and sets the
//   frame size to 640x480; line stores are not cleared
// stall
//   while res is stalled with a word held, the window stage holds and
//   pix.ready drops once that stage is also full
`timescale 1ns / 1ps
`default_nettype none

module opponent_color_lbp_3x3
  import ocl_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  ocl_pix_if.sink               pix,
  ocl_res_if.source             res
);

  localparam int CW = $clog2(MAX_WIDTH);

  // counter stage
  logic          accept;
  logic [CW-1:0] col_in;
  pos_t          pos_in;

  // window stage registers
  logic          v1;
  pixel_t        px1;
  logic [CW-1:0] c1;
  pos_t          pos1;
  logic          fwd;
  pixel_t        fwd_top;
  pixel_t        fwd_mid;
  logic          fire1;

  pixel_t        upper_rd;
  pixel_t        middle_rd;
  pixel_t        top1;
  pixel_t        mid1;

  // window columns c-2 and c-1: top, middle, bottom
  pixel_t        wc [6];
  win_t          win;
  code_set_t     codes;

  // output register
  logic          ov;

  assign fire1     = v1 && (!ov || res.ready);
  assign pix.ready = !v1 || fire1;
  assign accept    = pix.valid && pix.ready;

  ocl_position #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_position (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .advance    (accept),
    .frame_start(pix.frame_start),
    .col        (col_in),
    .pos        (pos_in)
  );

  // line stores, read when a word enters, written when it leaves the window stage
  ocl_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_upper (
    .clk  (clk),
    .we   (fire1),
    .waddr(c1),
    .wdata(mid1),
    .re   (accept),
    .raddr(col_in),
    .rdata(upper_rd)
  );

  ocl_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_middle (
    .clk  (clk),
    .we   (fire1),
    .waddr(c1),
    .wdata(px1),
    .re   (accept),
    .raddr(col_in),
    .rdata(middle_rd)
  );

  // column c as seen by the word in the window stage
  assign top1 = fwd ? fwd_top : upper_rd;
  assign mid1 = fwd ? fwd_mid : middle_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (accept) begin
      v1 <= 1'b1;
    end else if (fire1) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px1     <= {pix.chan_two, pix.chan_one, pix.chan_zero};
      c1      <= col_in;
      pos1    <= pos_in;
      // same column written back this cycle: ram read returns the old entry
      fwd     <= fire1 && (col_in == c1);
      fwd_top <= mid1;
      fwd_mid <= px1;
    end
  end

  always_comb begin
    win.tl  = wc[0];
    win.l   = wc[1];
    win.bl  = wc[2];
    win.t   = wc[3];
    win.ctr = wc[4];
    win.b   = wc[5];
    win.tr  = top1;
    win.rt  = mid1;
    win.br  = px1;
  end

  ocl_codes u_codes (
    .win  (win),
    .codes(codes)
  );

  // shift the window by one column per word
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        wc[i] <= '0;
      end
    end else if (fire1) begin
      wc[0] <= wc[3];
      wc[1] <= wc[4];
      wc[2] <= wc[5];
      wc[3] <= top1;
      wc[4] <= mid1;
      wc[5] <= px1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (fire1 && pos1.emit) begin
      ov <= 1'b1;
    end else if (res.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire1 && pos1.emit) begin
      res.code_n0_c0 <= codes[0];
      res.code_n1_c1 <= codes[1];
      res.code_n2_c2 <= codes[2];
      res.code_n1_c0 <= codes[3];
      res.code_n2_c0 <= codes[4];
      res.code_n2_c1 <= codes[5];
      res.center_row <= pos1.center_row;
      res.center_col <= pos1.center_col;
      res.frame_last <= pos1.last;
    end
  end

  assign res.valid = ov;

endmodule

`default_nettype wire

### bench/opponent_color_lbp_3x3_tb.sv
// self-checking bench for opponent_color_lbp_3x3: raster pixel words in, lbp result words out
// depends on ocl_pkg, ocl_if and the block itself; carries its own window predictor
`timescale 1ns / 1ps

module opponent_color_lbp_3x3_tb;
  import ocl_pkg::*;

  localparam int LINE_DEPTH   = 2048;
  localparam int CYCLE_LIMIT  = 600_000;
  localparam int SETTLE       = 8;      // settling margin after the last owed word comes back
  localparam int MAX_REPORTS  = 10;

  // neighbor and center channel of each of the six codes
  localparam int NBR_CH [NCODES] = '{0, 1, 2, 1, 2, 2};
  localparam int CTR_CH [NCODES] = '{0, 1, 2, 0, 0, 1};

  typedef struct packed {
    logic [CH_W-1:0]   n0c0;
    logic [CH_W-1:0]   n1c1;
    logic [CH_W-1:0]   n2c2;
    logic [CH_W-1:0]   n1c0;
    logic [CH_W-1:0]   n2c0;
    logic [CH_W-1:0]   n2c1;
    logic [ROW_W-1:0]  row;
    logic [CCOL_W-1:0] col;
    logic              last;
  } lbp_word_t;

  logic clk = 1'b0;
  logic rst;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  ocl_pix_if pix_ch ();
  ocl_res_if res_ch ();

  opponent_color_lbp_3x3 #(
    .MAX_WIDTH(LINE_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pix      (pix_ch),
    .res      (res_ch)
  );

  always #5 clk = ~clk;

  // predictor state: frame size registers, the two line stores, the window and position
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic [PIX_W-1:0] upper_line  [LINE_DEPTH];
  logic [PIX_W-1:0] middle_line [LINE_DEPTH];
  logic [PIX_W-1:0] win_cols    [6];
  int unsigned      col_pos;
  int unsigned      row_pos;

  // result words still owed by the block, oldest first
  lbp_word_t pending_codes [$];

  // traffic shaping
  int idle_pct;
  int stall_pct;
  int hold_len;
  bit hold_start;
  int hold_left;

  // bookkeeping
  int cycle_count;
  int words_sent;
  int words_checked;
  int reg_writes;
  int error_count;

  lbp_word_t got_word;
  lbp_word_t want_word;

  function automatic string show_word(lbp_word_t v);
    return $sformatf("codes %h %h %h %h %h %h row %0d col %0d last %0b",
                     v.n0c0, v.n1c1, v.n2c2, v.n1c0, v.n2c0, v.n2c1, v.row, v.col, v.last);
  endfunction

  // channel level biased toward extremes and near-equal values so >= ties happen
  function automatic logic [CH_W-1:0] pick_level();
    case ($urandom_range(3))
      0, 1: return CH_W'($urandom_range(255));
      2: return CH_W'($urandom_range(100, 103));
      default: return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] random_pixel();
    return {pick_level(), pick_level(), pick_level()};
  endfunction

  // window predictor: places one accepted pixel and queues the result word it completes
  task automatic compute_window_codes(input logic [PIX_W-1:0] px, input bit fs);
    int unsigned w, h, c, r;
    logic [PIX_W-1:0] top, mid;
    logic [PIX_W-1:0] ring [8];
    logic [CH_W-1:0]  cv;
    logic [CH_W-1:0]  codes [NCODES];
    lbp_word_t        e;
    w = width_reg;
    if (w < 3) w = 3;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    h = height_reg;
    if (h < 3) h = 3;
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    // a shrunken frame pushes the counters back in range first
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    c = col_pos;
    r = row_pos;
    top = upper_line[c];
    mid = middle_line[c];
    if (r >= 2 && c >= 2) begin
      // indexed by output bit position
      ring[0] = mid;          // right
      ring[1] = top;          // top-right
      ring[2] = win_cols[3];  // top
      ring[3] = win_cols[0];  // top-left
      ring[4] = win_cols[1];  // left
      ring[5] = win_cols[2];  // bottom-left
      ring[6] = win_cols[5];  // bottom
      ring[7] = px;           // bottom-right
      for (int k = 0; k < NCODES; k++) begin
        cv = win_cols[4][8*CTR_CH[k] +: 8];
        for (int b = 0; b < 8; b++) codes[k][b] = (cv >= ring[b][8*NBR_CH[k] +: 8]);
      end
      e.n0c0 = codes[0];
      e.n1c1 = codes[1];
      e.n2c2 = codes[2];
      e.n1c0 = codes[3];
      e.n2c0 = codes[4];
      e.n2c1 = codes[5];
      e.row  = ROW_W'(r - 1);
      e.col  = CCOL_W'(c - 1);
      e.last = (r == h - 1) && (c == w - 1);
      pending_codes.push_back(e);
    end
    win_cols[0] = win_cols[3];
    win_cols[1] = win_cols[4];
    win_cols[2] = win_cols[5];
    win_cols[3] = top;
    win_cols[4] = mid;
    win_cols[5] = px;
    upper_line[c]  = mid;
    middle_line[c] = px;
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  // offers one pixel word, idling first at the phase rate, and returns at the accepting edge
  // valid is left high so a following word goes out back to back
  task automatic send_pixel(input logic [PIX_W-1:0] px, input bit fs);
    while ($urandom_range(99) < idle_pct) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.chan_zero   <= px[7:0];
    pix_ch.chan_one    <= px[15:8];
    pix_ch.chan_two    <= px[23:16];
    pix_ch.frame_start <= fs;
    do begin
      @(posedge clk);
    end while (!pix_ch.ready);
    compute_window_codes(px, fs);
    words_sent++;
  endtask

  task automatic send_frame(input int count, input bit fs_first);
    for (int i = 0; i < count; i++) send_pixel(random_pixel(), fs_first && (i == 0));
  endtask

  // sender goes quiet until every owed result word is back, then waits out the SETTLE margin
  task automatic drain_results();
    pix_ch.valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // both size registers, written back to back while the block is idle
  task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    width_reg  = w;
    height_reg = h;
    reg_writes += 2;
  endtask

  // ---------------------------------------------------------------- tests

  // reset size 640 wide: a short run from reset stays on the top border, no words
  task automatic test_reset_size();
    idle_pct  = 0;
    stall_pct = 0;
    send_frame(16, 1'b0);
  endtask

  // 3x3 frames: flat, dark center, graded values; a frame_start mid-frame; end-of-frame wrap
  task automatic test_directed();
    logic [CH_W-1:0] g;
    set_frame(12'd3, 12'd3);
    for (int k = 0; k < 9; k++) send_pixel(24'h000000, k == 0);
    // two stray words, then a frame_start pulls the counters back
    send_pixel(24'hFFFFFF, 1'b0);
    send_pixel(24'h00FF00, 1'b0);
    for (int k = 0; k < 9; k++)
      send_pixel((k == 4) ? {8'd255, 8'd128, 8'd0} : 24'hFFFFFF, k == 0);
    // no frame_start: relies on the wrap after the last pixel
    for (int k = 0; k < 9; k++) begin
      g = CH_W'(k * 31);
      send_pixel({(k % 2 != 0) ? 8'hFF : 8'h00, 8'd255 - g, g}, 1'b0);
    end
  endtask

  // register values below the minimum saturate to 3
  task automatic test_size_saturation();
    set_frame(12'd0, 12'd1);
    send_frame(9, 1'b1);
    send_frame(9, 1'b0);
    set_frame(12'd2, 12'd2);
    send_frame(18, 1'b1);
  endtask

  // all-ones width saturates to the line store depth; a short run stays in row 0
  task automatic test_wide_frame();
    set_frame(12'hFFF, 12'd3);
    send_frame(20, 1'b1);
  endtask

  // tallest frame at the narrowest width, first rows only
  task automatic test_tall_frame();
    set_frame(12'd3, 12'hFFF);
    send_frame(3 * 12, 1'b1);
  endtask

  // shrink the frame under the counters so they wrap before the next pixel
  task automatic test_counter_wrap();
    set_frame(12'd12, 12'd6);
    send_frame(2 * 12 + 9, 1'b1);     // now at row 2, column 9
    set_frame(12'd5, 12'd6);          // column 9 past width: next row
    send_frame(12, 1'b0);             // now at row 5, column 2
    set_frame(12'd5, 12'd4);          // row 5 past height: back to row 0
    send_frame(24, 1'b0);
  endtask

  // long receiver hold fills the block and stalls its input; then a mid-stream drain
  task automatic test_backpressure();
    set_frame(12'd6, 12'd5);
    idle_pct  = 0;
    stall_pct = 0;
    hold_len   = 400;
    hold_start = 1'b1;
    send_frame(90, 1'b1);
    drain_results();
    send_frame(30, 1'b0);
  endtask

  // mostly whole frames with random content, some cut short, across the idle and stall phases
  task automatic test_random_traffic();
    int idle_tab  [4] = '{0, 75, 0, 7};
    int stall_tab [4] = '{0, 0, 75, 7};
    int fw, fh, n, len, sent;
    bit need_fs;
    for (int p = 0; p < 4; p++) begin
      fw = $urandom_range(3, 9);
      fh = $urandom_range(3, 6);
      set_frame(CFG_W'(fw), CFG_W'(fh));
      idle_pct  = idle_tab[p];
      stall_pct = stall_tab[p];
      need_fs = 1'b1;
      sent = 0;
      while (sent < 45) begin
        n = fw * fh;
        if ($urandom_range(99) < 80) begin
          // whole frame; frame_start optional when the last one ended cleanly
          send_frame(n, need_fs || ($urandom_range(1) != 0));
          need_fs = 1'b0;
          sent += n;
        end else begin
          len = $urandom_range(1, n - 1);
          send_frame(len, 1'b1);
          need_fs = 1'b1;
          sent += len;
        end
      end
    end
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  // ---------------------------------------------------------------- result side

  // takes result words, checks each against the oldest owed one, drives ready
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      got_word.n0c0 = res_ch.code_n0_c0;
      got_word.n1c1 = res_ch.code_n1_c1;
      got_word.n2c2 = res_ch.code_n2_c2;
      got_word.n1c0 = res_ch.code_n1_c0;
      got_word.n2c0 = res_ch.code_n2_c0;
      got_word.n2c1 = res_ch.code_n2_c1;
      got_word.row  = res_ch.center_row;
      got_word.col  = res_ch.center_col;
      got_word.last = res_ch.frame_last;
      if (pending_codes.size() == 0) begin
        if (error_count < MAX_REPORTS)
          $display("unexpected result word: %s", show_word(got_word));
        error_count++;
      end else begin
        want_word = pending_codes.pop_front();
        if (got_word !== want_word) begin
          if (error_count < MAX_REPORTS)
            $display("mismatch on word %0d: expected %s, got %s",
                     words_checked, show_word(want_word), show_word(got_word));
          error_count++;
        end
        words_checked++;
      end
    end
    // hold-off requested by a test is counted down here
    if (hold_start) begin
      hold_left  = hold_len;
      hold_start = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still owed", cycle_count,
               pending_codes.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = REG_FRAME_WIDTH;
    cfg_data           = '0;
    pix_ch.valid       = 1'b0;
    pix_ch.chan_zero   = '0;
    pix_ch.chan_one    = '0;
    pix_ch.chan_two    = '0;
    pix_ch.frame_start = 1'b0;
    res_ch.ready       = 1'b0;
    cycle_count   = 0;
    words_sent    = 0;
    words_checked = 0;
    reg_writes    = 0;
    error_count   = 0;
    idle_pct      = 0;
    stall_pct     = 0;
    hold_len      = 0;
    hold_start    = 1'b0;
    hold_left     = 0;
    // predictor after reset
    width_reg  = 12'd640;
    height_reg = 12'd480;
    col_pos    = 0;
    row_pos    = 0;
    for (int i = 0; i < 6; i++) win_cols[i] = '0;
    for (int i = 0; i < LINE_DEPTH; i++) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_reset_size();
    test_directed();
    test_size_saturation();
    test_counter_wrap();
    test_backpressure();
    test_random_traffic();
    test_wide_frame();
    test_tall_frame();

    drain_results();
    $display("sent %0d pixel words, checked %0d result words, %0d register writes",
             words_sent, words_checked, reg_writes);
    $display("small frames, size limits at both ends, counter wraps, stalls and idle gaps");
    if (error_count == 0 && pending_codes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d errors, %0d words still owed", error_count, pending_codes.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
